### rtl/core/vmoc_pkg.sv
// Package for the variable-size MRU object cache.
// Holds the request, response and cell types, sizes and status codes.
// No dependencies.
package vmoc_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int ID_W        = 20;
   localparam int SIZE_W      = 24;
   localparam int STATUS_W    = 3;
   localparam int EVICT_W     = 7;

   localparam logic [SIZE_W-1:0]  CAP_RESET = SIZE_W'(1048576);
   localparam logic [EVICT_W-1:0] EVICT_MAX = '1;

   localparam logic [STATUS_W-1:0] STATUS_HIT         = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_INSERTED    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_TOO_BIG     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_PRESENT = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL  = 3'd5;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   // Cell operations: keep, take the entry of the next cell up (pop toward
   // cell 0), or take the entry of the next cell down (push away from cell 0).
   localparam logic [1:0] CELL_HOLD = 2'd0;
   localparam logic [1:0] CELL_POP  = 2'd1;
   localparam logic [1:0] CELL_PUSH = 2'd2;

   typedef struct packed {
      logic               kind;
      logic [ID_W-1:0]    object_id;
      logic [SIZE_W-1:0]  object_size;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [EVICT_W-1:0]  evicted_count;
      logic [SIZE_W-1:0]   free_space_left;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic [1:0] op;
      logic       valid;
   } cell_ctrl_type;

endpackage

### rtl/core/vmoc_cell.sv
// One cell of the recency chain: holds one cached object and compares it.
// Depends on vmoc_pkg.
module vmoc_cell (
   input  logic                   clock,
   input  vmoc_pkg::cell_ctrl_type ctrl,
   input  vmoc_pkg::entry_type    lower,
   input  vmoc_pkg::entry_type    upper,
   input  logic [vmoc_pkg::ID_W-1:0] cmp_id,
   output vmoc_pkg::entry_type    entry,
   output logic                   match
);
   import vmoc_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      case (ctrl.op)
         CELL_POP:  entry_in = upper;
         CELL_PUSH: entry_in = lower;
         default:   entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = ctrl.valid && (entry_ff.id == cmp_id);

endmodule

### rtl/core/variable_size_mru_object_cache_top.sv
// Top level of the variable-size MRU object cache: sequencer and cell chain.
// Depends on vmoc_pkg and vmoc_cell.
//
// The cache keeps up to MAX_ENTRIES objects in a chain of cells, the most
// recent object in cell 0. A request is taken when start is high and busy is
// low; its single response appears on rsp_payload for exactly one cycle with
// rsp_valid high, and the receiver must take it then. A lookup or an insert
// that finds its id, is too big or hits a full table is answered from the
// decide state, after the compare state. Any other insert goes on to the
// evict state, where the chain pops one object from its most-recent end
// per cycle until the new object fits, then pushes the new object in at
// cell 0 and answers. Writing csr_wdata with csr_we empties the cache and
// sets the free space to the new capacity; write it only while busy is low.
module variable_size_mru_object_cache_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  vmoc_pkg::req_type    req_payload,
   output logic                 rsp_valid,
   output vmoc_pkg::rsp_type    rsp_payload,
   input  logic                 csr_we,
   input  logic [vmoc_pkg::SIZE_W-1:0] csr_wdata
);
   import vmoc_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CMP   = 2'd1;
   localparam logic [1:0] ST_DEC   = 2'd2;
   localparam logic [1:0] ST_EVICT = 2'd3;

   logic [1:0]             state_ff, state_in;
   req_type                req_ff, req_in;
   logic [SIZE_W-1:0]      cap_ff, cap_in;
   logic [SIZE_W-1:0]      free_ff, free_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [EVICT_W-1:0]     evict_ff, evict_in;
   logic [MAX_ENTRIES-1:0] match_ff, match_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   cell_ctrl_type          ctrl [MAX_ENTRIES];
   entry_type              cell_entry [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] cell_match;
   logic [MAX_ENTRIES-1:0] push_mask;
   entry_type              hit_entry;
   entry_type              load_entry;
   logic [1:0]             chain_op;
   logic                   use_mask;
   logic                   need_evict;

   // The chain: cell 0 takes load_entry when pushed, the last cell takes its
   // own entry when popped (that slot then falls out of the valid range).
   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      entry_type lower_k;
      entry_type upper_k;
      if (k == 0) begin : g_first
         assign lower_k = load_entry;
      end else begin : g_lower
         assign lower_k = cell_entry[k-1];
      end
      if (k == MAX_ENTRIES - 1) begin : g_last
         assign upper_k = cell_entry[k];
      end else begin : g_upper
         assign upper_k = cell_entry[k+1];
      end
      assign ctrl[k].valid = CNT_W'(k) < count_ff;
      assign ctrl[k].op    = use_mask ? (push_mask[k] ? CELL_PUSH : CELL_HOLD) : chain_op;
      vmoc_cell u_cell (
         .clock  (clock),
         .ctrl   (ctrl[k]),
         .lower  (lower_k),
         .upper  (upper_k),
         .cmp_id (req_ff.object_id),
         .entry  (cell_entry[k]),
         .match  (cell_match[k])
      );
   end

   // On a hit every cell at or below the matching one moves up by one and the
   // matching object re-enters at cell 0. Ids are unique, so at most one match.
   always_comb begin
      hit_entry = '0;
      for (int k = 0; k < MAX_ENTRIES; k++) begin
         push_mask[k] = |(match_ff >> k);
         if (match_ff[k]) begin
            hit_entry = hit_entry | cell_entry[k];
         end
      end
   end

   assign need_evict = (free_ff < req_ff.object_size) && (count_ff != '0);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cap_in       = cap_ff;
      free_in      = free_ff;
      count_in     = count_ff;
      evict_in     = evict_ff;
      match_in     = match_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      chain_op     = CELL_HOLD;
      use_mask     = 1'b0;
      load_entry   = hit_entry;

      case (state_ff)
         ST_IDLE: begin
            // A capacity write and a request in the same cycle are both taken;
            // the request then sees the new, empty cache.
            if (csr_we) begin
               cap_in   = csr_wdata;
               free_in  = csr_wdata;
               count_in = '0;
            end
            if (start) begin
               req_in   = req_payload;
               evict_in = '0;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            match_in = cell_match;
            state_in = ST_DEC;
         end
         ST_DEC: begin
            rsp_in.evicted_count   = '0;
            rsp_in.free_space_left = free_ff;
            if (req_ff.kind == KIND_LOOKUP) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (match_ff != '0) begin
                  use_mask      = 1'b1;
                  rsp_in.status = STATUS_HIT;
               end else begin
                  rsp_in.status = STATUS_NOT_PRESENT;
               end
            end else if (match_ff != '0) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_PRESENT;
               state_in      = ST_IDLE;
            end else if (req_ff.object_size > cap_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_TOO_BIG;
               state_in      = ST_IDLE;
            end else if ((count_ff == CNT_W'(MAX_ENTRIES)) &&
                         (free_ff >= req_ff.object_size)) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_TABLE_FULL;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            if (need_evict) begin
               // Drop the most recent object and reclaim its space.
               chain_op = CELL_POP;
               free_in  = free_ff + cell_entry[0].size;
               count_in = count_ff - 1'b1;
               if (evict_ff != EVICT_MAX) begin
                  evict_in = evict_ff + 1'b1;
               end
            end else begin
               // Room is there now: push the new object in at cell 0.
               chain_op              = CELL_PUSH;
               load_entry.id         = req_ff.object_id;
               load_entry.size       = req_ff.object_size;
               free_in               = free_ff - req_ff.object_size;
               count_in              = count_ff + 1'b1;
               rsp_valid_in          = 1'b1;
               rsp_in.status         = STATUS_INSERTED;
               rsp_in.evicted_count  = evict_ff;
               rsp_in.free_space_left = free_ff - req_ff.object_size;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         free_ff      <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      evict_ff <= evict_in;
      match_ff <= match_in;
      rsp_ff   <= rsp_in;
   end

   assign busy        = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/core/vmoc_checker.sv
// Port-level checker for the MRU object cache, bound to the top level.
// Depends on vmoc_pkg.
module vmoc_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input vmoc_pkg::rsp_type rsp_payload
);
   import vmoc_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but block not busy");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response held for more than one cycle");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= STATUS_TABLE_FULL)
      else $error("undefined status code");

   a_evict_only_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_INSERTED |->
         rsp_payload.evicted_count == '0)
      else $error("eviction count on a response that is no insert");

   a_evict_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.evicted_count <= EVICT_W'(MAX_ENTRIES))
      else $error("more evictions than entries");

endmodule

bind variable_size_mru_object_cache_top vmoc_checker u_vmoc_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

### dv/tb_top.sv
// Testbench for the variable-size MRU object cache: a self-checking run of
// directed and random lookup/insert requests across several capacity settings.
// Depends on vmoc_pkg and variable_size_mru_object_cache_top.
module tb_top;
   import vmoc_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = MAX_ENTRIES + 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_payload = '0;
   logic rsp_valid;
   rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [SIZE_W-1:0] csr_wdata = '0;

   variable_size_mru_object_cache_top dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Shadow copy of the cache contents. Slot 0 holds the least recent object
   // and slot cached_count-1 the most recent one.
   logic [ID_W-1:0]   cached_ids   [MAX_ENTRIES];
   logic [SIZE_W-1:0] cached_sizes [MAX_ENTRIES];
   int unsigned       cached_count;
   logic [SIZE_W-1:0] space_free;
   logic [SIZE_W-1:0] capacity;

   req_type pending_requests [$];
   rsp_type expected_responses [$];
   int error_count = 0;
   int cycle_count = 0;
   int gap_left = 0;
   bit bursty = 1'b0;

   // Writing the capacity empties the cache.
   function automatic void set_capacity(logic [SIZE_W-1:0] value);
      capacity = value;
      cached_count = 0;
      space_free = value;
   endfunction

   // Applies one request to the shadow cache and returns the response it
   // should produce.
   function automatic rsp_type predict_response(req_type rq);
      rsp_type rs;
      int slot;
      int evicted;
      logic [ID_W-1:0] hit_id;
      logic [SIZE_W-1:0] hit_size;
      slot = -1;
      evicted = 0;
      for (int i = 0; i < cached_count; i++)
         if (slot < 0 && cached_ids[i] == rq.object_id) slot = i;
      rs = '0;
      if (rq.kind == KIND_LOOKUP) begin
         if (slot < 0) begin
            rs.status = STATUS_NOT_PRESENT;
         end else begin
            // A hit moves the object to the most recent end.
            hit_id = cached_ids[slot];
            hit_size = cached_sizes[slot];
            for (int j = slot; j + 1 < cached_count; j++) begin
               cached_ids[j] = cached_ids[j+1];
               cached_sizes[j] = cached_sizes[j+1];
            end
            cached_ids[cached_count-1] = hit_id;
            cached_sizes[cached_count-1] = hit_size;
            rs.status = STATUS_HIT;
         end
      end else if (slot >= 0) begin
         rs.status = STATUS_PRESENT;
      end else if (rq.object_size > capacity) begin
         rs.status = STATUS_TOO_BIG;
      end else if (cached_count >= MAX_ENTRIES && space_free >= rq.object_size) begin
         rs.status = STATUS_TABLE_FULL;
      end else begin
         // Eviction takes objects from the most recent end.
         while (space_free < rq.object_size && cached_count > 0) begin
            cached_count--;
            space_free = space_free + cached_sizes[cached_count];
            if (evicted < 127) evicted++;
         end
         if (cached_count < MAX_ENTRIES && space_free >= rq.object_size) begin
            cached_ids[cached_count] = rq.object_id;
            cached_sizes[cached_count] = rq.object_size;
            cached_count++;
            space_free = space_free - rq.object_size;
            rs.status = STATUS_INSERTED;
            rs.evicted_count = EVICT_W'(evicted);
         end else begin
            rs.status = STATUS_TOO_BIG;
         end
      end
      rs.free_space_left = space_free;
      return rs;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch in %s: got %0d, expected %0d (cycle %0d)", what, got, want,
               cycle_count);
      error_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (bursty || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Sender: at each edge it notes an accepted request, then either holds the
   // current request, idles, or presents the next one. Every branch makes a
   // single assignment to start.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            expected_responses.insert(expected_responses.size(),
                                      predict_response(req_payload));
         if (start && busy) begin
            start <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_payload <= pending_requests.pop_front();
            start <= 1'b1;
            gap_left = pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Receiver: every strobed response is compared with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end else if (!reset && rsp_valid) begin
         if (expected_responses.size() == 0) begin
            $display("unexpected response at cycle %0d", cycle_count);
            error_count++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch("status", rsp_payload.status, want.status);
            if (rsp_payload.evicted_count !== want.evicted_count)
               report_mismatch("evicted_count", rsp_payload.evicted_count,
                               want.evicted_count);
            if (rsp_payload.free_space_left !== want.free_space_left)
               report_mismatch("free_space_left", rsp_payload.free_space_left,
                               want.free_space_left);
         end
      end
   end

   task automatic queue_request(logic kind, logic [ID_W-1:0] id, logic [SIZE_W-1:0] size);
      req_type rq;
      rq.kind = kind;
      rq.object_id = id;
      rq.object_size = size;
      pending_requests.insert(pending_requests.size(), rq);
   endtask

   // Waits until the sender has nothing left and every response has arrived,
   // then lets the longest possible eviction run out.
   task automatic wait_drained();
      while (pending_requests.size() > 0 || start || expected_responses.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [SIZE_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      set_capacity(value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Random requests: mostly operations on a small pool of ids so that hits,
   // duplicates, full tables and evictions occur, with some random-id noise.
   task automatic queue_random(int count, int pool, int unsigned size_cap);
      int r;
      logic [ID_W-1:0] id;
      logic [SIZE_W-1:0] size;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 8) id = ID_W'($urandom);
         else id = ID_W'($urandom_range(0, pool - 1)) ^ {ID_W{r[0] & r[3]}};
         r = $urandom_range(0, 99);
         if (r < 4) size = '0;
         else if (r < 8) size = SIZE_W'($urandom);
         else if (r < 11) size = capacity;
         else if (r < 70) size = SIZE_W'($urandom_range(1, size_cap / 64 + 1));
         else size = SIZE_W'($urandom_range(1, size_cap / 4 + 1));
         queue_request($urandom_range(0, 99) < 60 ? KIND_INSERT : KIND_LOOKUP, id, size);
      end
   endtask

   initial begin
      int unsigned cap_value;
      set_capacity(CAP_RESET);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed requests at the reset capacity.
      queue_request(KIND_LOOKUP, 20'd5, 24'd0);             // lookup miss on empty cache
      queue_request(KIND_INSERT, 20'd5, 24'd0);             // zero size
      queue_request(KIND_INSERT, 20'd5, 24'd10);            // already present
      queue_request(KIND_INSERT, 20'hFFFFF, 24'hFFFFFF);    // too big
      queue_request(KIND_INSERT, 20'hFFFFF, 24'd1000);
      queue_request(KIND_INSERT, 20'd0, 24'd2000);
      queue_request(KIND_LOOKUP, 20'd5, 24'hFFFFFF);        // hit, size ignored
      queue_request(KIND_LOOKUP, 20'hFFFFF, 24'd0);
      queue_request(KIND_INSERT, 20'h55555, 24'd1048576);   // evicts everything
      queue_request(KIND_LOOKUP, 20'd0, 24'd0);
      queue_request(KIND_INSERT, 20'hAAAAA, 24'd1);
      queue_request(KIND_INSERT, 20'h12345, 24'h0FFFFF);    // fills the free space exactly, no eviction
      queue_request(KIND_INSERT, 20'h12345, 24'd1);
      wait_drained();

      // A large budget with tiny objects fills the table and reports full.
      write_capacity(24'hFFFFFF);
      for (int i = 0; i < 70; i++)
         queue_request(KIND_INSERT, ID_W'(i), SIZE_W'($urandom_range(0, 300)));
      queue_request(KIND_INSERT, 20'd999, 24'hFFFFFF);      // evicts until the whole budget is free
      queue_random(80, 96, 2000);
      wait_drained();

      write_capacity(24'd0);
      queue_random(40, 8, 4);
      wait_drained();

      for (int phase = 0; phase < 9; phase++) begin
         case (phase % 4)
            0: cap_value = $urandom_range(64, 5000);
            1: cap_value = 24'hFFFFFF;
            2: cap_value = $urandom_range(1, 24'hFFFFFF);
            default: cap_value = $urandom_range(100000, 2000000);
         endcase
         bursty = (phase % 3 == 1);
         write_capacity(SIZE_W'(cap_value));
         queue_random(120, (phase % 2) ? 80 : 24,
                      (phase % 4 == 1) ? 20000 : cap_value);
         wait_drained();
      end

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

### variable_size_mru_object_cache_top.f
rtl/core/vmoc_pkg.sv
rtl/core/vmoc_cell.sv
rtl/core/variable_size_mru_object_cache_top.sv
rtl/core/vmoc_checker.sv
dv/tb_top.sv
